// ===== design/tps_pkg.sv =====
// Shared types, constants and helpers for the three-class partition sorter.
// Depends on nothing; every other design file imports it.
package tps_pkg;

	localparam int COLOR_W = 2;
	localparam int LENGTH_W = 16;
	localparam int MAX_ITEMS_DEF = 64;
	localparam int LENGTH_BITS_DEF = 16;

	localparam logic [COLOR_W-1:0] COLOR_BLUE = 2'd0;
	localparam logic [COLOR_W-1:0] COLOR_GREEN = 2'd1;
	localparam logic [COLOR_W-1:0] COLOR_RED = 2'd2;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic insert;
		logic pop;
		logic pop_last;
		logic pop_ovf;
	} tps_cmd_t;

	// Any code other than blue or red is treated as green.
	function automatic logic [COLOR_W-1:0] map_color(input logic [COLOR_W-1:0] code);
		logic [COLOR_W-1:0] res;
		case (code)
			COLOR_BLUE: res = COLOR_BLUE;
			COLOR_RED: res = COLOR_RED;
			default: res = COLOR_GREEN;
		endcase
		return res;
	endfunction

endpackage

// ===== design/tps_ctrl.sv =====
// Controller of the sorter: load and drain phases, item count, drop flag, output valid.
// Depends on tps_pkg.
module tps_ctrl #(
	parameter int MAX_ITEMS = tps_pkg::MAX_ITEMS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic last_in,
	output logic out_valid,
	input  logic out_ready,
	output tps_pkg::tps_cmd_t cmd
);
	import tps_pkg::*;

	localparam int CNT_W = $clog2(MAX_ITEMS + 1);
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_ITEMS);
	localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

	localparam logic [0:0] ST_LOAD = 1'b0;
	localparam logic [0:0] ST_DRAIN = 1'b1;

	logic [0:0] state_q;
	logic [CNT_W-1:0] count_q;
	logic dropped_q;
	logic out_valid_q;
	logic accept;
	logic has_room;
	logic pop;

	assign in_ready = (state_q == ST_LOAD);
	assign accept = in_valid && in_ready;
	assign has_room = (count_q < CNT_MAX);
	assign pop = (state_q == ST_DRAIN) && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd.insert = accept && has_room;
		cmd.pop = pop;
		cmd.pop_last = (count_q == CNT_ONE);
		cmd.pop_ovf = dropped_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			count_q <= '0;
			dropped_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_LOAD: begin
					if (accept) begin
						if (has_room) begin
							count_q <= count_q + CNT_ONE;
						end else begin
							dropped_q <= 1'b1;
						end
						if (last_in) begin
							state_q <= ST_DRAIN;
						end
					end
				end
				ST_DRAIN: begin
					if (pop) begin
						count_q <= count_q - CNT_ONE;
						if (count_q == CNT_ONE) begin
							state_q <= ST_LOAD;
							dropped_q <= 1'b0;
						end
					end
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_MAX)
		else $error("item count exceeds capacity");

	a_drain_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DRAIN) |-> (count_q != '0))
		else $error("drain phase with an empty store");

	a_last_pop_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && count_q == CNT_ONE) |=> (state_q == ST_LOAD && count_q == '0 && !dropped_q))
		else $error("final pop did not return to load phase");

	a_pop_shows: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> out_valid_q)
		else $error("popped item not presented");

endmodule

// ===== design/tps_datapath.sv =====
// Datapath of the sorter: a sorted insertion chain of key cells and the output register.
// Depends on tps_pkg; driven by commands from tps_ctrl.
module tps_datapath #(
	parameter int MAX_ITEMS = tps_pkg::MAX_ITEMS_DEF,
	parameter int LENGTH_BITS = tps_pkg::LENGTH_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  tps_pkg::tps_cmd_t cmd,
	input  logic [tps_pkg::COLOR_W-1:0] color_code,
	input  logic [tps_pkg::LENGTH_W-1:0] length,
	output logic [tps_pkg::COLOR_W-1:0] out_color,
	output logic [tps_pkg::LENGTH_W-1:0] out_length,
	output logic last_out,
	output logic overflow
);
	import tps_pkg::*;

	localparam int KEY_W = COLOR_W + LENGTH_BITS;

	logic [LENGTH_BITS-1:0] len_c;
	logic [KEY_W-1:0] new_key;
	logic [KEY_W-1:0] key_q [MAX_ITEMS];
	logic [MAX_ITEMS-1:0] vld_q;
	logic [MAX_ITEMS-1:0] gt;
	logic [COLOR_W-1:0] out_color_q;
	logic [LENGTH_W-1:0] out_length_q;
	logic last_q;
	logic ovf_q;

	// Saturate the length when the stored key is narrower than the port.
	if (LENGTH_BITS >= LENGTH_W) begin : g_len_wide
		assign len_c = LENGTH_BITS'(length);
	end else begin : g_len_narrow
		assign len_c = ((length >> LENGTH_BITS) != '0) ? '1 : length[LENGTH_BITS-1:0];
	end

	assign new_key = {map_color(color_code), len_c};

	// An empty cell counts as greater, so the chain stays sorted with empties at the top.
	always_comb begin
		for (int i = 0; i < MAX_ITEMS; i++) begin
			gt[i] = !vld_q[i] || (key_q[i] > new_key);
		end
	end

	for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
		logic take_new;
		if (i == 0) begin : g_first
			assign take_new = 1'b1;
		end else begin : g_rest
			assign take_new = !gt[i-1];
		end

		always_ff @(posedge clk) begin
			if (cmd.insert && gt[i]) begin
				key_q[i] <= take_new ? new_key : key_q[(i == 0) ? 0 : i - 1];
			end else if (cmd.pop && i < MAX_ITEMS - 1) begin
				key_q[i] <= key_q[(i < MAX_ITEMS - 1) ? i + 1 : i];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_q[i] <= 1'b0;
			end else if (cmd.insert && gt[i]) begin
				vld_q[i] <= take_new ? 1'b1 : vld_q[(i == 0) ? 0 : i - 1];
			end else if (cmd.pop) begin
				vld_q[i] <= (i < MAX_ITEMS - 1) ? vld_q[(i < MAX_ITEMS - 1) ? i + 1 : i] : 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.pop) begin
			out_color_q <= key_q[0][KEY_W-1 -: COLOR_W];
			out_length_q <= LENGTH_W'(key_q[0][LENGTH_BITS-1:0]);
			last_q <= cmd.pop_last;
			ovf_q <= cmd.pop_ovf;
		end
	end

	assign out_color = out_color_q;
	assign out_length = out_length_q;
	assign last_out = last_q;
	assign overflow = ovf_q;

	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop |-> vld_q[0])
		else $error("pop from an empty chain");

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.pop && cmd.insert))
		else $error("insert and pop in the same cycle");

	a_last_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.pop && cmd.pop_last) |=> (vld_q == '0))
		else $error("chain not empty after final pop");

endmodule

// ===== design/three_class_partition_sorter.sv =====
// Top level of the three-class partition sorter: controller plus insertion-chain datapath.
// Depends on tps_pkg, tps_ctrl and tps_datapath.
//
//  channel | handshake           | payload
//  input   | in_valid / in_ready | color_code, length, last_in
//  output  | out_valid/out_ready | out_color, out_length, last_out, overflow
//
// Each input item is placed directly in the sorted chain, so a set loads at one item
// per cycle; the chain compares all cells with the new key in parallel.
// After the item marked last, the set drains at one result per cycle from the head of the
// chain unless the output stalls; the next set may load once the final result is taken
// into the output register. A stalled output holds the chain. Reset clears all valid bits.
module three_class_partition_sorter #(
	parameter int MAX_ITEMS = tps_pkg::MAX_ITEMS_DEF,
	parameter int LENGTH_BITS = tps_pkg::LENGTH_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic [tps_pkg::COLOR_W-1:0] color_code,
	input  logic [tps_pkg::LENGTH_W-1:0] length,
	input  logic last_in,
	output logic out_valid,
	input  logic out_ready,
	output logic [tps_pkg::COLOR_W-1:0] out_color,
	output logic [tps_pkg::LENGTH_W-1:0] out_length,
	output logic last_out,
	output logic overflow
);
	import tps_pkg::*;

	tps_cmd_t cmd;

	tps_ctrl #(
		.MAX_ITEMS(MAX_ITEMS)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.last_in(last_in),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.cmd(cmd)
	);

	tps_datapath #(
		.MAX_ITEMS(MAX_ITEMS),
		.LENGTH_BITS(LENGTH_BITS)
	) u_datapath (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.color_code(color_code),
		.length(length),
		.out_color(out_color),
		.out_length(out_length),
		.last_out(last_out),
		.overflow(overflow)
	);

endmodule
